FILE: rtl/p24_pkg.sv
// Shared types, constants and round functions for the PRESENT-24 decrypt block.
`timescale 1ns / 1ps
`default_nettype none
package p24_pkg;

   localparam int BLOCK_W  = 24;
   localparam int NUM_KEYS = 11;
   localparam int PADDR_W  = 6;
   localparam int PDATA_W  = 64;
   localparam int REG_IDX_W = 3;

   typedef logic [BLOCK_W-1:0] block_type;
   typedef logic [NUM_KEYS-1:0][BLOCK_W-1:0] key_set_type;
   typedef logic [REG_IDX_W-1:0] reg_idx_type;

   localparam reg_idx_type REG_KEYS_0_1 = 3'd0;
   localparam reg_idx_type REG_KEYS_2_3 = 3'd1;
   localparam reg_idx_type REG_KEYS_4_5 = 3'd2;
   localparam reg_idx_type REG_KEYS_6_7 = 3'd3;
   localparam reg_idx_type REG_KEYS_8_9 = 3'd4;
   localparam reg_idx_type REG_KEY_TEN  = 3'd5;

   typedef struct packed {
      logic               psel;
      logic               penable;
      logic               pwrite;
      logic [PADDR_W-1:0] paddr;
      logic [PDATA_W-1:0] pwdata;
   } csr_req_type;

   localparam logic [4:0] PERM_DEST [0:BLOCK_W-1] = '{
      5'd0, 5'd4, 5'd8, 5'd12, 5'd16, 5'd20, 5'd1, 5'd5, 5'd9, 5'd13, 5'd17, 5'd21,
      5'd2, 5'd6, 5'd10, 5'd14, 5'd18, 5'd22, 5'd3, 5'd7, 5'd11, 5'd15, 5'd19, 5'd23
   };

   localparam logic [3:0] SBOX_INV [0:15] = '{
      4'h5, 4'hE, 4'hF, 4'h8, 4'hC, 4'h1, 4'h2, 4'hD,
      4'hB, 4'h4, 4'h6, 4'h3, 4'h0, 4'h7, 4'h9, 4'hA
   };

   function automatic block_type inv_permute(input block_type s);
      block_type r;
      r = '0;
      for (int i = 0; i < BLOCK_W; i++) begin
         r[PERM_DEST[i]] = s[i];
      end
      return r;
   endfunction

   function automatic block_type inv_substitute(input block_type s);
      block_type r;
      r = '0;
      for (int n = 0; n < BLOCK_W / 4; n++) begin
         r[4*n +: 4] = SBOX_INV[s[4*n +: 4]];
      end
      return r;
   endfunction

endpackage
`default_nettype wire

FILE: rtl/p24_key_regs.sv
// Round key register file behind the APB-style configuration port.
`timescale 1ns / 1ps
`default_nettype none
module p24_key_regs (
   input  wire                          clock,
   input  wire                          reset,
   input  p24_pkg::csr_req_type         csr_req,
   output logic [p24_pkg::PDATA_W-1:0]  prdata,
   output p24_pkg::key_set_type         keys
);
   import p24_pkg::*;

   key_set_type keys_ff;
   key_set_type keys_in;
   reg_idx_type reg_idx;
   logic        write_en;

   assign reg_idx  = csr_req.paddr[PADDR_W-1:PADDR_W-REG_IDX_W];
   assign write_en = csr_req.psel && csr_req.penable && csr_req.pwrite;

   always_comb begin
      keys_in = keys_ff;
      if (write_en) begin
         case (reg_idx)
            REG_KEYS_0_1: begin
               keys_in[0] = csr_req.pwdata[BLOCK_W-1:0];
               keys_in[1] = csr_req.pwdata[2*BLOCK_W-1:BLOCK_W];
            end
            REG_KEYS_2_3: begin
               keys_in[2] = csr_req.pwdata[BLOCK_W-1:0];
               keys_in[3] = csr_req.pwdata[2*BLOCK_W-1:BLOCK_W];
            end
            REG_KEYS_4_5: begin
               keys_in[4] = csr_req.pwdata[BLOCK_W-1:0];
               keys_in[5] = csr_req.pwdata[2*BLOCK_W-1:BLOCK_W];
            end
            REG_KEYS_6_7: begin
               keys_in[6] = csr_req.pwdata[BLOCK_W-1:0];
               keys_in[7] = csr_req.pwdata[2*BLOCK_W-1:BLOCK_W];
            end
            REG_KEYS_8_9: begin
               keys_in[8] = csr_req.pwdata[BLOCK_W-1:0];
               keys_in[9] = csr_req.pwdata[2*BLOCK_W-1:BLOCK_W];
            end
            REG_KEY_TEN: begin
               keys_in[10] = csr_req.pwdata[BLOCK_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         REG_KEYS_0_1: prdata = {16'd0, keys_ff[1], keys_ff[0]};
         REG_KEYS_2_3: prdata = {16'd0, keys_ff[3], keys_ff[2]};
         REG_KEYS_4_5: prdata = {16'd0, keys_ff[5], keys_ff[4]};
         REG_KEYS_6_7: prdata = {16'd0, keys_ff[7], keys_ff[6]};
         REG_KEYS_8_9: prdata = {16'd0, keys_ff[9], keys_ff[8]};
         REG_KEY_TEN:  prdata = {40'd0, keys_ff[10]};
         default:      prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         keys_ff <= '0;
      end else begin
         keys_ff <= keys_in;
      end
   end

   assign keys = keys_ff;

endmodule
`default_nettype wire

FILE: rtl/p24_round_cell.sv
// One decryption round cell: inverse permutation, inverse S-box, key add, stage register.
`timescale 1ns / 1ps
`default_nettype none
module p24_round_cell (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  valid_in,
   input  p24_pkg::block_type   data_in,
   input  p24_pkg::block_type   round_key,
   input  wire                  ready_in,
   output logic                 ready_out,
   output logic                 valid_out,
   output p24_pkg::block_type   data_out
);
   import p24_pkg::*;

   logic      valid_ff;
   block_type data_ff;
   block_type data_in_next;

   assign ready_out    = !valid_ff || ready_in;
   assign data_in_next = inv_substitute(inv_permute(data_in)) ^ round_key;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (ready_out) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ready_out && valid_in) begin
         data_ff <= data_in_next;
      end
   end

   assign valid_out = valid_ff;
   assign data_out  = data_ff;

endmodule
`default_nettype wire

FILE: rtl/present24_block_decrypt.sv
// Top level: reduced PRESENT 24-bit block decryption as a chain of round cells.
//
//   Channel   Direction  Handshake               Payload
//   req_      in         req_valid / req_stall   req_cipher_block [23:0]
//   rsp_      out        rsp_valid / rsp_stall   rsp_plain_block  [23:0]
//   csr_      in/out     APB-style, pready = 1   64-bit data, byte address 8*index
//
// One block enters per cycle while req_stall is low; each block passes through ROUNDS round cells.
// The last cell's register is the output register; each cell holds while its
// downstream neighbor is full and stalled, so bubbles close up under a stall.
// Reset clears all cell valid bits and sets every round key to zero.
`timescale 1ns / 1ps
`default_nettype none
module present24_block_decrypt #(
   parameter int ROUNDS = 10
) (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          req_valid,
   output logic                         req_stall,
   input  wire  [23:0]                  req_cipher_block,
   output logic                         rsp_valid,
   input  wire                          rsp_stall,
   output logic [23:0]                  rsp_plain_block,
   input  wire                          csr_psel,
   input  wire                          csr_penable,
   input  wire                          csr_pwrite,
   input  wire  [p24_pkg::PADDR_W-1:0]  csr_paddr,
   input  wire  [p24_pkg::PDATA_W-1:0]  csr_pwdata,
   output logic [p24_pkg::PDATA_W-1:0]  csr_prdata,
   output logic                         csr_pready
);
   import p24_pkg::*;

   csr_req_type csr_req;
   key_set_type keys;
   logic        stage_valid [0:ROUNDS];
   block_type   stage_data  [0:ROUNDS];
   logic        stage_ready [0:ROUNDS];

   assign csr_req.psel    = csr_psel;
   assign csr_req.penable = csr_penable;
   assign csr_req.pwrite  = csr_pwrite;
   assign csr_req.paddr   = csr_paddr;
   assign csr_req.pwdata  = csr_pwdata;
   assign csr_pready      = 1'b1;

   p24_key_regs u_key_regs (
      .clock   (clock),
      .reset   (reset),
      .csr_req (csr_req),
      .prdata  (csr_prdata),
      .keys    (keys)
   );

   assign stage_valid[0] = req_valid;
   assign stage_data[0]  = req_cipher_block ^ keys[ROUNDS];
   assign req_stall      = !stage_ready[0];

   for (genvar g = 0; g < ROUNDS; g++) begin : g_cell
      p24_round_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .valid_in  (stage_valid[g]),
         .data_in   (stage_data[g]),
         .round_key (keys[ROUNDS-1-g]),
         .ready_in  (stage_ready[g+1]),
         .ready_out (stage_ready[g]),
         .valid_out (stage_valid[g+1]),
         .data_out  (stage_data[g+1])
      );
   end

   assign stage_ready[ROUNDS] = !rsp_stall;
   assign rsp_valid           = stage_valid[ROUNDS];
   assign rsp_plain_block     = stage_data[ROUNDS];

endmodule
`default_nettype wire

FILE: rtl/p24_port_checker.sv
// Port-level checks for the PRESENT-24 decrypt block, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module p24_port_checker (
   input wire                          clock,
   input wire                          reset,
   input wire                          req_stall,
   input wire                          rsp_valid,
   input wire                          rsp_stall,
   input wire  [23:0]                  rsp_plain_block,
   input wire                          csr_psel,
   input wire                          csr_penable,
   input wire                          csr_pwrite,
   input wire  [p24_pkg::PADDR_W-1:0]  csr_paddr,
   input wire  [p24_pkg::PDATA_W-1:0]  csr_pwdata,
   input wire  [p24_pkg::PDATA_W-1:0]  csr_prdata,
   input wire                          csr_pready
);
   import p24_pkg::*;

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_plain_block))
      else $error("stalled result changed");

   a_no_false_stall: assert property (@(posedge clock) disable iff (reset)
      (!rsp_valid || !rsp_stall) |-> !req_stall)
      else $error("input stalled while output side can drain");

   a_key_ten_readback: assert property (@(posedge clock) disable iff (reset)
      (csr_psel && csr_penable && csr_pwrite && csr_pready &&
       csr_paddr[PADDR_W-1:PADDR_W-REG_IDX_W] == REG_KEY_TEN) ##1
      (!csr_pwrite && csr_paddr[PADDR_W-1:PADDR_W-REG_IDX_W] == REG_KEY_TEN)
      |-> csr_prdata == {40'd0, $past(csr_pwdata[BLOCK_W-1:0])})
      else $error("round key ten read back wrong");

endmodule

bind present24_block_decrypt p24_port_checker u_port_checker (
   .clock           (clock),
   .reset           (reset),
   .req_stall       (req_stall),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_plain_block (rsp_plain_block),
   .csr_psel        (csr_psel),
   .csr_penable     (csr_penable),
   .csr_pwrite      (csr_pwrite),
   .csr_paddr       (csr_paddr),
   .csr_pwdata      (csr_pwdata),
   .csr_prdata      (csr_prdata),
   .csr_pready      (csr_pready)
);
`default_nettype wire
